// ===== design/dlbp_pkg.sv =====
// ----------------------------------------------------------------------------
// dlbp_pkg
// Types and constants shared by the definite-length block word parser.
// ----------------------------------------------------------------------------
package dlbp_pkg;

	localparam int BYTE_W   = 8;
	localparam int SAMPLE_W = 14;
	localparam int STATUS_W = 3;
	localparam int DIGIT_W  = 4;
	localparam int LEN_W    = 30;
	localparam int LIMIT_W  = LEN_W - 1;
	localparam int CFG_W    = 18;

	localparam logic [BYTE_W-1:0]   CH_HASH     = 8'h23;
	localparam logic [BYTE_W-1:0]   CH_ZERO     = 8'h30;
	localparam logic [BYTE_W-1:0]   CH_NINE     = 8'h39;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = 14'h3FFF;

	typedef enum logic [4:0] {
		PH_HASH   = 5'b00001,
		PH_COUNT  = 5'b00010,
		PH_DIGITS = 5'b00100,
		PH_DATA   = 5'b01000,
		PH_SKIP   = 5'b10000
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_SAMPLE     = 3'd0,
		ST_BAD        = 3'd1,
		ST_HDR_SHORT  = 3'd2,
		ST_TOO_LONG   = 3'd3,
		ST_DATA_SHORT = 3'd4,
		ST_EMPTY      = 3'd5
	} status_t;

	typedef struct packed {
		phase_t              phase;
		logic [DIGIT_W-1:0]  digits_left;
		logic [LEN_W-1:0]    length_count;
		logic [BYTE_W-1:0]   low_byte;
		logic                low_byte_held;
	} parse_state_t;

	typedef struct packed {
		logic                valid;
		logic [SAMPLE_W-1:0] sample;
		status_t             status;
		logic                last;
	} result_t;

endpackage

// ===== design/dlbp_ifs.sv =====
// ----------------------------------------------------------------------------
// dlbp channel interfaces
// Valid/ready channels for reply bytes and for parse results.
// ----------------------------------------------------------------------------
interface dlbp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_reply;

	modport source (output valid, output byte_in, output end_of_reply, input ready);
	modport sink   (input valid, input byte_in, input end_of_reply, output ready);
endinterface

interface dlbp_result_if;
	logic        valid;
	logic        ready;
	logic [13:0] sample;
	logic [2:0]  status;
	logic        last;

	modport source (output valid, output sample, output status, output last, input ready);
	modport sink   (input valid, input sample, input status, input last, output ready);
endinterface

// ===== design/definite_length_block_word_parser.sv =====
// ----------------------------------------------------------------------------
// definite_length_block_word_parser
// Parses '#', a count digit, decimal length digits and data bytes, and
// emits 14-bit little-endian words or one status result per block fault.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake     Carries
//  in_ch     sink       valid/ready   byte_in, end_of_reply
//  out_ch    source     valid/ready   sample, status, last
//  cfg       write      cfg_wr_en     cfg_wr_data = max_words
//
//  One byte a cycle: a byte sits in the input register while
//  the parse logic updates the state and fills the result register.
//  A byte that yields no result moves on even while a result is stalled;
//  a byte that yields a result waits for the result register to free up.
//  arst_n returns the parser to expecting a hash and max_words to MAX_WORDS.
// ----------------------------------------------------------------------------
module definite_length_block_word_parser #(
	parameter int MAX_WORDS = 131072
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dlbp_byte_if.sink                     in_ch,
	dlbp_result_if.source                 out_ch,
	input  logic                          cfg_wr_en,
	input  logic [dlbp_pkg::CFG_W-1:0]    cfg_wr_data
);
	import dlbp_pkg::*;

	localparam int LIM_BITS = $clog2(MAX_WORDS + 1);
	localparam int MW_W     = (LIM_BITS > CFG_W) ? LIM_BITS : CFG_W;
	localparam logic [MW_W-1:0] MW_MAX = MW_W'(MAX_WORDS);

	logic [MW_W-1:0]    max_words_q;
	logic [MW_W-1:0]    limit_full;
	logic [LIMIT_W-1:0] limit;

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               eor_s1;

	parse_state_t       state_q;
	parse_state_t       state_nxt;
	result_t            res;
	logic               adv;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] sample_q;
	status_t             status_q;
	logic                last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_words_q <= MW_MAX;
		end else if (cfg_wr_en) begin
			max_words_q <= MW_W'(cfg_wr_data);
		end
	end

	assign limit_full = (max_words_q < MW_MAX) ? max_words_q : MW_MAX;
	assign limit      = LIMIT_W'(limit_full);

	dlbp_step u_step (
		.cur          (state_q),
		.byte_in      (byte_s1),
		.end_of_reply (eor_s1),
		.limit        (limit),
		.nxt          (state_nxt),
		.res          (res)
	);

	// A byte without a result never waits on the output side.
	assign adv         = valid_s1 && (!res.valid || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.byte_in;
			eor_s1  <= in_ch.end_of_reply;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_HASH, digits_left: '0, length_count: '0,
				low_byte: '0, low_byte_held: 1'b0};
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			sample_q <= res.sample;
			status_q <= res.status;
			last_q   <= res.last;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.sample = sample_q;
	assign out_ch.status = status_q;
	assign out_ch.last   = last_q;

	// Every fault result closes the reply and carries no sample.
	a_fault_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_SAMPLE |-> last_q && sample_q == '0)
		else $error("fault result without last or with a sample");

	a_data_has_bytes_due: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_DATA |-> state_q.length_count != '0)
		else $error("data phase with no bytes due");

	a_held_only_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.low_byte_held |-> state_q.phase == PH_DATA)
		else $error("low byte held outside the data phase");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.valid |=> out_valid_q)
		else $error("result lost on its way to the output register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |-> !(adv && res.valid))
		else $error("pending result overwritten");

endmodule

// ===== design/dlbp_step.sv =====
// ----------------------------------------------------------------------------
// dlbp_step
// Next-state and result logic of the parser for one reply byte.
// ----------------------------------------------------------------------------
module dlbp_step (
	input  dlbp_pkg::parse_state_t          cur,
	input  logic [7:0]                      byte_in,
	input  logic                            end_of_reply,
	input  logic [dlbp_pkg::LIMIT_W-1:0]    limit,
	output dlbp_pkg::parse_state_t          nxt,
	output dlbp_pkg::result_t               res
);
	import dlbp_pkg::*;

	logic                is_digit;
	logic [DIGIT_W-1:0]  digit;
	logic [LEN_W-1:0]    len_acc;
	logic [DIGIT_W-1:0]  dl_dec;
	logic [LEN_W-1:0]    lc_dec;
	logic [2*BYTE_W-1:0] data_word;
	parse_state_t        done_st;

	assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	assign digit    = DIGIT_W'(byte_in - CH_ZERO);
	// Times ten as two shifted copies.
	assign len_acc  = (cur.length_count << 3) + (cur.length_count << 1)
		+ LEN_W'(digit);
	assign dl_dec   = cur.digits_left - DIGIT_W'(1);
	assign lc_dec   = cur.length_count - LEN_W'(1);
	// The first data byte of a pair is the low half of the word.
	assign data_word = {byte_in, cur.low_byte};

	always_comb begin
		done_st               = '0;
		done_st.phase         = end_of_reply ? PH_HASH : PH_SKIP;
	end

	always_comb begin
		nxt = cur;
		res = '{valid: 1'b0, sample: '0, status: ST_SAMPLE, last: 1'b0};
		unique case (cur.phase)
			PH_HASH: begin
				if (byte_in != CH_HASH || end_of_reply) begin
					nxt = done_st;
					res = '{valid: 1'b1, sample: '0, status: ST_BAD, last: 1'b1};
				end else begin
					nxt.phase = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (!is_digit || byte_in == CH_ZERO) begin
					nxt = done_st;
					res = '{valid: 1'b1, sample: '0, status: ST_BAD, last: 1'b1};
				end else if (end_of_reply) begin
					nxt = done_st;
					res = '{valid: 1'b1, sample: '0, status: ST_HDR_SHORT, last: 1'b1};
				end else begin
					nxt.digits_left  = digit;
					nxt.length_count = '0;
					nxt.phase        = PH_DIGITS;
				end
			end
			PH_DIGITS: begin
				nxt.length_count = len_acc;
				nxt.digits_left  = dl_dec;
				priority if (!is_digit) begin
					nxt = done_st;
					res = '{valid: 1'b1, sample: '0, status: ST_BAD, last: 1'b1};
				end else if (dl_dec != '0) begin
					if (end_of_reply) begin
						nxt = done_st;
						res = '{valid: 1'b1, sample: '0, status: ST_HDR_SHORT,
							last: 1'b1};
					end
				end else if (len_acc[0]) begin
					nxt = done_st;
					res = '{valid: 1'b1, sample: '0, status: ST_BAD, last: 1'b1};
				end else if (len_acc[LEN_W-1:1] > limit) begin
					nxt = done_st;
					res = '{valid: 1'b1, sample: '0, status: ST_TOO_LONG, last: 1'b1};
				end else if (len_acc == '0) begin
					nxt = done_st;
					res = '{valid: 1'b1, sample: '0, status: ST_EMPTY, last: 1'b1};
				end else if (end_of_reply) begin
					nxt = done_st;
					res = '{valid: 1'b1, sample: '0, status: ST_DATA_SHORT, last: 1'b1};
				end else begin
					nxt.low_byte      = '0;
					nxt.low_byte_held = 1'b0;
					nxt.phase         = PH_DATA;
				end
			end
			PH_DATA: begin
				nxt.length_count = lc_dec;
				if (!cur.low_byte_held) begin
					nxt.low_byte      = byte_in;
					nxt.low_byte_held = 1'b1;
					if (end_of_reply) begin
						nxt = done_st;
						res = '{valid: 1'b1, sample: '0, status: ST_DATA_SHORT,
							last: 1'b1};
					end
				end else begin
					nxt.low_byte      = '0;
					nxt.low_byte_held = 1'b0;
					if (lc_dec == '0) begin
						nxt = done_st;
						res = '{valid: 1'b1,
							sample: data_word[SAMPLE_W-1:0] & SAMPLE_MASK,
							status: ST_SAMPLE, last: 1'b1};
					end else if (end_of_reply) begin
						nxt = done_st;
						res = '{valid: 1'b1, sample: '0, status: ST_DATA_SHORT,
							last: 1'b1};
					end else begin
						res = '{valid: 1'b1,
							sample: data_word[SAMPLE_W-1:0] & SAMPLE_MASK,
							status: ST_SAMPLE, last: 1'b0};
					end
				end
			end
			PH_SKIP: begin
				if (end_of_reply) begin
					nxt = done_st;
				end
			end
			default: begin
				nxt = done_st;
			end
		endcase
	end

endmodule
